FILE: hw/rtl/shuffled_lehmer_random_generator_top_assert.svh
// Assertion macros for the shuffled Lehmer random generator.
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_TOP_ASSERT_SVH

// check while out of reset
`define SLRG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every edge, reset included
`define SLRG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/slrg_pkg.sv
// Shared constants and types of the shuffled Lehmer random generator.
`default_nettype none

package slrg_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 32;
  localparam int unsigned WARMUP_STEPS_DEF  = 8;

  localparam int unsigned SEED_W   = 32;
  localparam int unsigned SAMPLE_W = 31;
  localparam int unsigned MUL_W    = 15;
  localparam int unsigned PROD_W   = SEED_W + MUL_W;

  localparam logic [MUL_W-1:0]    LEHMER_MUL = 15'd16807;
  localparam logic [SAMPLE_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 31'd2147483389;

  typedef logic [SEED_W-1:0]   seed_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_DIV,
    ST_DRAW_MUL,
    ST_DRAW_RED
  } state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/slrg_seed_if.sv
// Valid/ready channel carrying one seed word.
`default_nettype none

interface slrg_seed_if import slrg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SEED_W-1:0] seed_value;

  modport source (output valid, output seed_value, input ready);
  modport sink   (input valid, input seed_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/slrg_sample_if.sv
// Valid/ready channel carrying one random sample word.
`default_nettype none

interface slrg_sample_if import slrg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] random_sample;

  modport source (output valid, output random_sample, input ready);
  modport sink   (input valid, input random_sample, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/slrg_lehmer_unit.sv
// Shared Lehmer step unit: registered multiply by 16807, then fold modulo 2^31-1.
`default_nettype none

module slrg_lehmer_unit import slrg_pkg::*; (
  input  logic    clk_i,
  input  logic    load_i,
  input  seed_t   operand_i,
  output sample_t result_o
);

  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;
  logic [SAMPLE_W:0] fold;
  logic [SAMPLE_W:0] fold_sub;

  assign prod_d = {{MUL_W{1'b0}}, operand_i} * {{SEED_W{1'b0}}, LEHMER_MUL};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign fold     = {1'b0, prod_q[SAMPLE_W-1:0]}
                  + (SAMPLE_W+1)'(prod_q[PROD_W-1:SAMPLE_W]);
  assign fold_sub = fold - {1'b0, LEHMER_MOD};
  assign result_o = (fold >= {1'b0, LEHMER_MOD}) ? fold_sub[SAMPLE_W-1:0]
                                                : fold[SAMPLE_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/shuffled_lehmer_random_generator_top.sv
// Top level of the shuffled Lehmer random generator with its shuffle table.
//
//   channel   dir   word            accepted when
//   seed_i    in    seed_value      seed_i.valid  && seed_i.ready
//   sample_o  out   random_sample   sample_o.valid && sample_o.ready
//
// A plain draw steps through accept, multiply with table read, and fold with table write.
// A table size that does not give a power-of-two slot divisor adds a shift-and-subtract divide before the draw.
// A nonzero seed first runs WarmupSteps warm-up steps, then fills the table, through the shared Lehmer unit.
// The final step stalls while the output register still holds an untaken word.
// Reset clears control state and the table valid bits; no clearing pass is needed.
`default_nettype none

module shuffled_lehmer_random_generator_top import slrg_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DEF,
  parameter int unsigned WarmupSteps  = WARMUP_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  slrg_seed_if.sink     seed_i,
  slrg_sample_if.source sample_o
);

  localparam int unsigned IdxW      = $clog2(TableEntries);
  localparam int unsigned QuoW      = IdxW + 1;
  localparam int unsigned BitCW     = $clog2(QuoW);
  localparam int unsigned StepTotal = WarmupSteps + TableEntries;
  localparam int unsigned CntW      = $clog2(StepTotal);
  localparam int unsigned TrialW    = SAMPLE_W + QuoW;
  localparam longint unsigned SlotDivL = 64'd1 + (64'd2147483646 / TableEntries);
  localparam logic [SAMPLE_W-1:0] SlotDiv = SAMPLE_W'(SlotDivL);
  localparam bit SlotPow2 = ((SlotDivL & (SlotDivL - 64'd1)) == 64'd0);
  localparam int unsigned SlotShift = $clog2(SlotDivL);

  state_e               state_q, state_d;
  seed_t                x_q, x_d;
  sample_t              gen_q, gen_d;
  sample_t              last_q, last_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [IdxW-1:0]      fill_idx_q, fill_idx_d;
  sample_t              rem_q, rem_d;
  logic [QuoW-1:0]      quo_q, quo_d;
  logic [BitCW-1:0]     bitc_q, bitc_d;
  logic                 out_valid_q, out_valid_d;
  sample_t              out_data_q, out_data_d;

  sample_t              tbl_mem [TableEntries];
  logic [TableEntries-1:0] vld_q;
  sample_t              rd_data_q;
  logic                 rd_vld_q;

  logic                 unit_load;
  seed_t                unit_operand;
  sample_t              unit_result;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  sample_t              mem_wdata;
  logic                 mem_re;

  seed_t                seed_raw;
  seed_t                seed_mag;
  sample_t              slot_full;
  logic [IdxW-1:0]      slot_idx;
  logic [TrialW-1:0]    trial;
  sample_t              new_last;
  logic                 out_free;

  slrg_lehmer_unit u_lehmer (
    .clk_i     (clk_i),
    .load_i    (unit_load),
    .operand_i (unit_operand),
    .result_o  (unit_result)
  );

  assign seed_raw  = seed_i.seed_value;
  assign seed_mag  = seed_raw[SEED_W-1] ? (SEED_W'(0) - seed_raw) : seed_raw;
  assign slot_full = SlotPow2 ? (last_q >> SlotShift) : SAMPLE_W'(quo_q);
  assign slot_idx  = (slot_full >= SAMPLE_W'(TableEntries)) ? IdxW'(TableEntries - 1)
                                                            : slot_full[IdxW-1:0];
  assign trial     = {{QuoW{1'b0}}, SlotDiv} << bitc_q;
  assign new_last  = rd_vld_q ? rd_data_q : '0;
  assign out_free  = !out_valid_q || sample_o.ready;

  assign seed_i.ready           = (state_q == ST_IDLE);
  assign sample_o.valid         = out_valid_q;
  assign sample_o.random_sample = out_data_q;

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    gen_d        = gen_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    fill_idx_d   = fill_idx_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    bitc_d       = bitc_q;
    out_valid_d  = out_valid_q && !sample_o.ready;
    out_data_d   = out_data_q;
    unit_load    = 1'b0;
    unit_operand = x_q;
    mem_we       = 1'b0;
    mem_waddr    = slot_idx;
    mem_wdata    = unit_result;
    mem_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (seed_i.valid) begin
          if (seed_raw != '0) begin
            x_d        = seed_mag;
            cnt_d      = '0;
            fill_idx_d = IdxW'(TableEntries - 1);
            state_d    = ST_SEED_MUL;
          end else if (SlotPow2) begin
            state_d = ST_DRAW_MUL;
          end else begin
            rem_d   = last_q;
            quo_d   = '0;
            bitc_d  = BitCW'(QuoW - 1);
            state_d = ST_DIV;
          end
        end
      end
      ST_SEED_MUL: begin
        unit_load = 1'b1;
        state_d   = ST_SEED_RED;
      end
      ST_SEED_RED: begin
        x_d = {1'b0, unit_result};
        if (cnt_q >= CntW'(WarmupSteps)) begin
          mem_we     = 1'b1;
          mem_waddr  = fill_idx_q;
          fill_idx_d = fill_idx_q - 1'b1;
        end
        if (cnt_q == CntW'(StepTotal - 1)) begin
          gen_d  = unit_result;
          last_d = unit_result;
          if (SlotPow2) begin
            state_d = ST_DRAW_MUL;
          end else begin
            rem_d   = unit_result;
            quo_d   = '0;
            bitc_d  = BitCW'(QuoW - 1);
            state_d = ST_DIV;
          end
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_SEED_MUL;
        end
      end
      ST_DIV: begin
        if ({{QuoW{1'b0}}, rem_q} >= trial) begin
          rem_d = rem_q - trial[SAMPLE_W-1:0];
          quo_d = quo_q | (QuoW'(1) << bitc_q);
        end
        if (bitc_q == '0) begin
          state_d = ST_DRAW_MUL;
        end else begin
          bitc_d = bitc_q - 1'b1;
        end
      end
      ST_DRAW_MUL: begin
        unit_load    = 1'b1;
        unit_operand = {1'b0, gen_q};
        mem_re       = 1'b1;
        state_d      = ST_DRAW_RED;
      end
      ST_DRAW_RED: begin
        if (out_free) begin
          gen_d       = unit_result;
          mem_we      = 1'b1;
          last_d      = new_last;
          out_valid_d = 1'b1;
          out_data_d  = (new_last > SAMPLE_MAX) ? SAMPLE_MAX : new_last;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[slot_idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    cnt_q      <= cnt_d;
    fill_idx_q <= fill_idx_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    bitc_q     <= bitc_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= tbl_mem[slot_idx];
    end
  end

`include "shuffled_lehmer_random_generator_top_assert.svh"

  `SLRG_ASSERT(a_sample_sat, sample_o.valid |-> (sample_o.random_sample <= SAMPLE_MAX), "sample above saturation limit")
  `SLRG_ASSERT(a_gen_reduced, gen_q != LEHMER_MOD, "generator value not reduced")
  `SLRG_ASSERT(a_busy_after_accept, (seed_i.valid && seed_i.ready) |=> !seed_i.ready, "ready right after accept")
  `SLRG_ASSERT_ALWAYS(a_word_from_draw, (rst_ni && $rose(out_valid_q)) |-> $past(state_q == ST_DRAW_RED), "output word without draw")

endmodule

`default_nettype wire
